[design/tced_pkg.sv]
// Shared types and constants for the tracker cell effect decoder.
// No dependencies; used by every module of the block except tced_checker.
`timescale 1ns / 1ps

package tced_pkg;

    localparam logic [7:0] NOTE_VOL_ONLY = 8'hFE;
    localparam logic [7:0] NOTE_EMPTY    = 8'hFF;
    localparam logic [7:0] NO_EFFECT     = 8'hFF;
    localparam logic [6:0] NOTE_BASE     = 7'd36;

    localparam logic [3:0] FX_TO_F   = 4'h0;
    localparam logic [3:0] FX_TO_E   = 4'h1;
    localparam logic [3:0] FX_TO_G   = 4'h2;
    localparam logic [3:0] FX_FINE_E = 4'h3;
    localparam logic [3:0] FX_TO_H   = 4'h4;
    localparam logic [3:0] FX_SPEED  = 4'h5;
    localparam logic [3:0] FX_PAN    = 4'h6;
    localparam logic [3:0] FX_TO_Q   = 4'h7;

    localparam logic [6:0] LETTER_A = 7'h41;
    localparam logic [6:0] LETTER_E = 7'h45;
    localparam logic [6:0] LETTER_F = 7'h46;
    localparam logic [6:0] LETTER_G = 7'h47;
    localparam logic [6:0] LETTER_H = 7'h48;
    localparam logic [6:0] LETTER_P = 7'h50;
    localparam logic [6:0] LETTER_Q = 7'h51;

    localparam logic [7:0] PARAM_FINE_ZERO = 8'hF1;
    localparam logic [3:0] PARAM_FINE_HI   = 4'hF;
    localparam logic [3:0] PARAM_H_HI      = 4'h8;
    localparam logic [7:0] PARAM_PAN_LEFT  = 8'h8F;
    localparam logic [7:0] PARAM_PAN_RIGHT = 8'hF8;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       note_present;
        logic [6:0] note_number;
        logic [6:0] instrument;
        logic       volume_present;
        logic [5:0] volume;
        logic [7:0] effect;
    } cell_t;

    typedef struct packed {
        logic       note_present;
        logic [6:0] note_number;
        logic [6:0] instrument;
        logic       volume_present;
        logic [5:0] volume;
        logic [6:0] effect_letter;
        logic [7:0] effect_param;
    } result_t;

endpackage

[design/tced_front.sv]
// Front stage: decodes note, instrument and volume and updates the per-channel
// sticky effect bytes. Depends on tced_pkg.
`timescale 1ns / 1ps

module tced_front #(
    parameter int CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                op,
    input  logic [2:0]          channel,
    input  logic [7:0]          note_byte,
    input  logic [7:0]          volume_byte,
    input  logic [7:0]          effect_byte,
    output tced_pkg::cell_t     decoded
);

    localparam int DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam logic [3:0] DEPTH_LIM = 4'(DEPTH);

    logic [7:0] sticky_reg  [DEPTH];
    logic [7:0] sticky_next [DEPTH];
    logic [7:0] sticky_rd;
    logic [7:0] eff;
    logic [7:0] wr_val;
    logic       ch_ok;
    logic       clr;

    always_comb
    begin
        sticky_rd = tced_pkg::NO_EFFECT;
        for (int i = 0; i < DEPTH; i++)
        begin
            if ({1'b0, channel} == 4'(i))
            begin
                sticky_rd = sticky_reg[i];
            end
        end
        if (op)
        begin
            sticky_rd = tced_pkg::NO_EFFECT;
        end
        ch_ok = ({1'b0, channel} < DEPTH_LIM);
        if (!ch_ok || (effect_byte != tced_pkg::NO_EFFECT))
        begin
            eff = effect_byte;
        end
        else
        begin
            eff = sticky_rd;
        end
        clr = (eff[7:4] == tced_pkg::FX_FINE_E) || (eff[7:4] == tced_pkg::FX_SPEED);
        wr_val = clr ? tced_pkg::NO_EFFECT : eff;
        for (int i = 0; i < DEPTH; i++)
        begin
            if ({1'b0, channel} == 4'(i))
            begin
                sticky_next[i] = wr_val;
            end
            else if (op)
            begin
                sticky_next[i] = tced_pkg::NO_EFFECT;
            end
            else
            begin
                sticky_next[i] = sticky_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                sticky_reg[i] <= tced_pkg::NO_EFFECT;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                sticky_reg[i] <= sticky_next[i];
            end
        end
    end

    always_comb
    begin
        decoded = '0;
        decoded.effect = eff;
        if (note_byte == tced_pkg::NOTE_VOL_ONLY)
        begin
            decoded.volume_present = 1'b1;
            decoded.volume         = {volume_byte[3:0], 2'b00};
        end
        else if (note_byte != tced_pkg::NOTE_EMPTY)
        begin
            decoded.note_present   = 1'b1;
            decoded.note_number    = {1'b0, note_byte[7:2]} + tced_pkg::NOTE_BASE;
            decoded.instrument     = {1'b0, note_byte[1:0], volume_byte[7:4]} + 7'd1;
            decoded.volume_present = 1'b1;
            decoded.volume         = {volume_byte[3:0], 2'b00};
        end
    end

endmodule

[design/tced_queue.sv]
// Short queue between the front and back stages.
// Depends on tced_pkg for the item type and depth.
`timescale 1ns / 1ps

module tced_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  tced_pkg::cell_t  wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             rd_valid,
    output tced_pkg::cell_t  rd_data
);

    localparam int DEPTH = tced_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tced_pkg::cell_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/tced_back.sv]
// Back stage: translates the kept effect byte to letter and parameter and
// holds the result item in the output register. Depends on tced_pkg.
`timescale 1ns / 1ps

module tced_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  tced_pkg::cell_t   in_cell,
    output logic              take,
    input  logic              pop,
    output logic              out_valid,
    output tced_pkg::result_t out_item
);

    logic              valid_reg, valid_next;
    tced_pkg::result_t item_reg, item_next;
    logic [3:0]        p;

    assign take      = in_valid && (!valid_reg || pop);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign p         = in_cell.effect[3:0];

    always_comb
    begin
        item_next.note_present   = in_cell.note_present;
        item_next.note_number    = in_cell.note_number;
        item_next.instrument     = in_cell.instrument;
        item_next.volume_present = in_cell.volume_present;
        item_next.volume         = in_cell.volume;
        item_next.effect_letter  = '0;
        item_next.effect_param   = '0;
        if (in_cell.effect != tced_pkg::NO_EFFECT)
        begin
            unique case (in_cell.effect[7:4])
                tced_pkg::FX_TO_F:
                begin
                    item_next.effect_letter = tced_pkg::LETTER_F;
                    item_next.effect_param  = {4'h0, p};
                end
                tced_pkg::FX_TO_E:
                begin
                    item_next.effect_letter = tced_pkg::LETTER_E;
                    item_next.effect_param  = {4'h0, p};
                end
                tced_pkg::FX_TO_G:
                begin
                    item_next.effect_letter = tced_pkg::LETTER_G;
                    item_next.effect_param  = {4'h0, p};
                end
                tced_pkg::FX_FINE_E:
                begin
                    item_next.effect_letter = tced_pkg::LETTER_E;
                    item_next.effect_param  = (p == 4'h0) ? tced_pkg::PARAM_FINE_ZERO
                                                          : {tced_pkg::PARAM_FINE_HI, p};
                end
                tced_pkg::FX_TO_H:
                begin
                    item_next.effect_letter = tced_pkg::LETTER_H;
                    item_next.effect_param  = {tced_pkg::PARAM_H_HI, p};
                end
                tced_pkg::FX_SPEED:
                begin
                    if (p != 4'h0)
                    begin
                        item_next.effect_letter = tced_pkg::LETTER_A;
                        item_next.effect_param  = {4'h0, p};
                    end
                end
                tced_pkg::FX_PAN:
                begin
                    if (p == 4'h0)
                    begin
                        item_next.effect_letter = tced_pkg::LETTER_P;
                        item_next.effect_param  = tced_pkg::PARAM_PAN_LEFT;
                    end
                    else if (p == 4'h1)
                    begin
                        item_next.effect_letter = tced_pkg::LETTER_P;
                        item_next.effect_param  = tced_pkg::PARAM_PAN_RIGHT;
                    end
                end
                tced_pkg::FX_TO_Q:
                begin
                    item_next.effect_letter = tced_pkg::LETTER_Q;
                    item_next.effect_param  = {4'h0, p};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[design/tracker_cell_effect_decoder.sv]
// Top level of the tracker cell effect decoder.
// Instantiates tced_front, tced_queue and tced_back; depends on tced_pkg.
//
// Takes one pattern cell per clock while full is low and delivers one result
// item per cell, in order; each accepted cell passes through the queue and the
// back stage into the output register. When the result side keeps up, the
// sustained rate is one item per cycle, set by the read, update and write-back
// of the channel's sticky effect byte in the front stage. full rises when the
// two-entry queue between front and back fills, which happens only when pop is
// held low; the output register holds the oldest result while empty is low.
`timescale 1ns / 1ps

module tracker_cell_effect_decoder #(
    parameter int CHANNELS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       op,
    input  logic [2:0] channel,
    input  logic [7:0] note_byte,
    input  logic [7:0] volume_byte,
    input  logic [7:0] effect_byte,
    output logic       empty,
    input  logic       pop,
    output logic       note_present,
    output logic [6:0] note_number,
    output logic [6:0] instrument,
    output logic       volume_present,
    output logic [5:0] volume,
    output logic [6:0] effect_letter,
    output logic [7:0] effect_param
);

    logic              accept;
    logic              q_full;
    logic              q_valid;
    logic              q_take;
    logic              out_valid;
    tced_pkg::cell_t   front_cell;
    tced_pkg::cell_t   q_cell;
    tced_pkg::result_t out_item;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_valid;

    tced_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .channel     (channel),
        .note_byte   (note_byte),
        .volume_byte (volume_byte),
        .effect_byte (effect_byte),
        .decoded     (front_cell)
    );

    tced_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_data  (front_cell),
        .full     (q_full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_data  (q_cell)
    );

    tced_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_cell   (q_cell),
        .take      (q_take),
        .pop       (pop),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign note_present   = out_item.note_present;
    assign note_number    = out_item.note_number;
    assign instrument     = out_item.instrument;
    assign volume_present = out_item.volume_present;
    assign volume         = out_item.volume;
    assign effect_letter  = out_item.effect_letter;
    assign effect_param   = out_item.effect_param;

endmodule

[design/tced_checker.sv]
// Port-level checks for tracker_cell_effect_decoder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module tced_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       note_present,
    input logic [6:0] note_number,
    input logic [6:0] instrument,
    input logic       volume_present,
    input logic [5:0] volume,
    input logic [6:0] effect_letter,
    input logic [7:0] effect_param
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(effect_param) && $stable(effect_letter)
                              && $stable(note_number) && $stable(instrument)))
        else $error("result item changed while stalled");

    a_note_has_volume: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && note_present) |-> volume_present)
        else $error("note without volume");

    a_absent_note_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !note_present) |-> (note_number == 7'd0 && instrument == 7'd0))
        else $error("absent note with nonzero fields");

    a_no_letter_no_param: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && effect_letter == 7'd0) |-> (effect_param == 8'd0))
        else $error("effect parameter without letter");

    a_volume_scaled: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (volume[1:0] == 2'b00 && (volume_present || volume == 6'd0)))
        else $error("volume not a multiple of four or present flag mismatch");

endmodule

bind tracker_cell_effect_decoder tced_checker u_tced_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .note_present   (note_present),
    .note_number    (note_number),
    .instrument     (instrument),
    .volume_present (volume_present),
    .volume         (volume),
    .effect_letter  (effect_letter),
    .effect_param   (effect_param)
);

[tb/tb_tracker_cell_effect_decoder.sv]
// Self-checking testbench for tracker_cell_effect_decoder: queued cells drive the
// push side, and each popped result is checked against a per-channel sticky predictor.
// Depends on tced_pkg and the tracker_cell_effect_decoder RTL.
`timescale 1ns / 1ps

module tb_tracker_cell_effect_decoder;

    localparam int   NUM_CHANNELS   = 8;
    localparam int   RANDOM_CELLS   = 900;
    localparam int   CYCLE_LIMIT    = 40000;
    localparam int   DRAIN_CYCLES   = 10;
    localparam int   HOLD_AT_CELL   = 300;
    localparam int   HOLD_CYCLES    = 200;
    localparam int   STEADY_FIRST   = 500;
    localparam int   STEADY_LAST    = 700;
    localparam logic OP_DECODE      = 1'b0;
    localparam logic OP_NEW_PATTERN = 1'b1;

    typedef struct {
        logic       op;
        logic [2:0] channel;
        logic [7:0] note_byte;
        logic [7:0] volume_byte;
        logic [7:0] effect_byte;
    } cell_in_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       push           = 1'b0;
    logic       full;
    logic       op             = OP_DECODE;
    logic [2:0] channel        = '0;
    logic [7:0] note_byte      = '0;
    logic [7:0] volume_byte    = '0;
    logic [7:0] effect_byte    = '0;
    logic       empty;
    logic       pop            = 1'b0;
    logic       note_present;
    logic [6:0] note_number;
    logic [6:0] instrument;
    logic       volume_present;
    logic [5:0] volume;
    logic [6:0] effect_letter;
    logic [7:0] effect_param;

    cell_in_t          pending_cells[$];
    tced_pkg::result_t expected_cells[$];
    logic [7:0]        sticky_fx [NUM_CHANNELS];
    cell_in_t          next_cell;
    logic              hold_pop        = 1'b0;
    logic              steady          = 1'b0;
    int                total_cells     = 0;
    int                cells_accepted  = 0;
    int                results_checked = 0;
    int                mismatches      = 0;
    int                cycles          = 0;

    tracker_cell_effect_decoder #(
        .CHANNELS(NUM_CHANNELS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .channel       (channel),
        .note_byte     (note_byte),
        .volume_byte   (volume_byte),
        .effect_byte   (effect_byte),
        .empty         (empty),
        .pop           (pop),
        .note_present  (note_present),
        .note_number   (note_number),
        .instrument    (instrument),
        .volume_present(volume_present),
        .volume        (volume),
        .effect_letter (effect_letter),
        .effect_param  (effect_param)
    );

    always #2 clk = ~clk;

    function automatic logic translate_effect(input logic [7:0] eff,
                                              output logic [6:0] letter,
                                              output logic [7:0] param);
        logic [3:0] p;
        logic       clr;
        p      = eff[3:0];
        clr    = 1'b0;
        letter = '0;
        param  = '0;
        if (eff != tced_pkg::NO_EFFECT)
        begin
            case (eff[7:4])
                tced_pkg::FX_TO_F:
                begin
                    letter = tced_pkg::LETTER_F;
                    param  = {4'h0, p};
                end
                tced_pkg::FX_TO_E:
                begin
                    letter = tced_pkg::LETTER_E;
                    param  = {4'h0, p};
                end
                tced_pkg::FX_TO_G:
                begin
                    letter = tced_pkg::LETTER_G;
                    param  = {4'h0, p};
                end
                tced_pkg::FX_FINE_E:
                begin
                    letter = tced_pkg::LETTER_E;
                    param  = (p != 4'h0) ? {tced_pkg::PARAM_FINE_HI, p}
                                         : tced_pkg::PARAM_FINE_ZERO;
                    clr    = 1'b1;
                end
                tced_pkg::FX_TO_H:
                begin
                    letter = tced_pkg::LETTER_H;
                    param  = {tced_pkg::PARAM_H_HI, p};
                end
                tced_pkg::FX_SPEED:
                begin
                    if (p != 4'h0)
                    begin
                        letter = tced_pkg::LETTER_A;
                        param  = {4'h0, p};
                    end
                    clr = 1'b1;
                end
                tced_pkg::FX_PAN:
                begin
                    if (p == 4'h0)
                    begin
                        letter = tced_pkg::LETTER_P;
                        param  = tced_pkg::PARAM_PAN_LEFT;
                    end
                    else if (p == 4'h1)
                    begin
                        letter = tced_pkg::LETTER_P;
                        param  = tced_pkg::PARAM_PAN_RIGHT;
                    end
                end
                tced_pkg::FX_TO_Q:
                begin
                    letter = tced_pkg::LETTER_Q;
                    param  = {4'h0, p};
                end
                default:
                begin
                end
            endcase
        end
        return clr;
    endfunction

    function automatic tced_pkg::result_t predict_cell(input cell_in_t c);
        tced_pkg::result_t r;
        logic [6:0]        letter;
        logic [7:0]        param;
        logic              clr;
        r = '0;
        if (c.op == OP_NEW_PATTERN)
        begin
            foreach (sticky_fx[i])
                sticky_fx[i] = tced_pkg::NO_EFFECT;
        end
        if (c.note_byte == tced_pkg::NOTE_VOL_ONLY)
        begin
            r.volume_present = 1'b1;
            r.volume         = {c.volume_byte[3:0], 2'b00};
        end
        else if (c.note_byte != tced_pkg::NOTE_EMPTY)
        begin
            r.note_present   = 1'b1;
            r.note_number    = {1'b0, c.note_byte[7:2]} + tced_pkg::NOTE_BASE;
            r.instrument     = {1'b0, c.note_byte[1:0], c.volume_byte[7:4]} + 7'd1;
            r.volume_present = 1'b1;
            r.volume         = {c.volume_byte[3:0], 2'b00};
        end
        if (int'(c.channel) < NUM_CHANNELS)
        begin
            if (c.effect_byte != tced_pkg::NO_EFFECT)
                sticky_fx[c.channel] = c.effect_byte;
            clr = translate_effect(sticky_fx[c.channel], letter, param);
            if (clr)
                sticky_fx[c.channel] = tced_pkg::NO_EFFECT;
        end
        else
        begin
            void'(translate_effect(c.effect_byte, letter, param));
        end
        r.effect_letter = letter;
        r.effect_param  = param;
        return r;
    endfunction

    task automatic add_cell(input logic o, input logic [2:0] ch, input logic [7:0] nb,
                            input logic [7:0] vb, input logic [7:0] eb);
        cell_in_t c;
        c.op          = o;
        c.channel     = ch;
        c.note_byte   = nb;
        c.volume_byte = vb;
        c.effect_byte = eb;
        pending_cells.push_back(c);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic check_result();
        tced_pkg::result_t want;
        if (expected_cells.size() == 0)
        begin
            report_mismatch("unexpected result", int'(effect_letter), 0);
        end
        else
        begin
            want = expected_cells.pop_front();
            if (note_present !== want.note_present)
                report_mismatch("note_present", int'(note_present),
                                int'(want.note_present));
            if (note_number !== want.note_number)
                report_mismatch("note_number", int'(note_number), int'(want.note_number));
            if (instrument !== want.instrument)
                report_mismatch("instrument", int'(instrument), int'(want.instrument));
            if (volume_present !== want.volume_present)
                report_mismatch("volume_present", int'(volume_present),
                                int'(want.volume_present));
            if (volume !== want.volume)
                report_mismatch("volume", int'(volume), int'(want.volume));
            if (effect_letter !== want.effect_letter)
                report_mismatch("effect_letter", int'(effect_letter),
                                int'(want.effect_letter));
            if (effect_param !== want.effect_param)
                report_mismatch("effect_param", int'(effect_param), int'(want.effect_param));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push        <= 1'b0;
            op          <= OP_DECODE;
            channel     <= '0;
            note_byte   <= '0;
            volume_byte <= '0;
            effect_byte <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_cells.push_back(predict_cell('{op, channel, note_byte,
                                                        volume_byte, effect_byte}));
                cells_accepted <= cells_accepted + 1;
            end
            steady <= (cells_accepted >= STEADY_FIRST) && (cells_accepted < STEADY_LAST);
            if (push && full)
            begin
                // hold the offered item
            end
            else if (pending_cells.size() != 0 && (steady || $urandom_range(99) >= 15))
            begin
                next_cell = pending_cells.pop_front();
                push        <= 1'b1;
                op          <= next_cell.op;
                channel     <= next_cell.channel;
                note_byte   <= next_cell.note_byte;
                volume_byte <= next_cell.volume_byte;
                effect_byte <= next_cell.effect_byte;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_result();
                results_checked <= results_checked + 1;
            end
            pop <= !hold_pop && (steady || $urandom_range(99) >= 15);
        end
    end

    initial
    begin
        while (cells_accepted < HOLD_AT_CELL)
            @(posedge clk);
        hold_pop <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pop <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_tracker_cell_effect_decoder failed");
            $finish;
        end
    end

    initial
    begin
        int         r;
        logic       o;
        logic [7:0] nb;
        logic [7:0] eb;
        foreach (sticky_fx[i])
            sticky_fx[i] = tced_pkg::NO_EFFECT;

        add_cell(OP_NEW_PATTERN, 3'd0, 8'h00, 8'h00, 8'h00);
        add_cell(OP_DECODE, 3'd1, 8'hFD, 8'hFF, 8'h1F);
        add_cell(OP_DECODE, 3'd2, tced_pkg::NOTE_VOL_ONLY, 8'h5A, 8'h2F);
        add_cell(OP_DECODE, 3'd3, tced_pkg::NOTE_EMPTY, 8'hFF, 8'h30);
        add_cell(OP_DECODE, 3'd3, tced_pkg::NOTE_EMPTY, 8'h00, tced_pkg::NO_EFFECT);
        add_cell(OP_DECODE, 3'd4, 8'h55, 8'hA5, 8'h3A);
        add_cell(OP_DECODE, 3'd5, 8'hAA, 8'h5A, 8'h4C);
        add_cell(OP_DECODE, 3'd5, 8'h01, 8'h12, tced_pkg::NO_EFFECT);
        add_cell(OP_DECODE, 3'd6, 8'h02, 8'h34, 8'h50);
        add_cell(OP_DECODE, 3'd6, 8'h03, 8'h56, 8'h57);
        add_cell(OP_DECODE, 3'd7, 8'h7C, 8'h78, 8'h60);
        add_cell(OP_DECODE, 3'd7, 8'h80, 8'h9A, 8'h61);
        add_cell(OP_DECODE, 3'd7, 8'hC3, 8'hBC, 8'h62);
        add_cell(OP_DECODE, 3'd7, tced_pkg::NOTE_VOL_ONLY, 8'hDE, tced_pkg::NO_EFFECT);
        add_cell(OP_DECODE, 3'd0, 8'h40, 8'hF0, 8'h7F);
        add_cell(OP_DECODE, 3'd1, 8'h10, 8'h0F, 8'h80);
        add_cell(OP_DECODE, 3'd1, tced_pkg::NOTE_EMPTY, 8'h11, tced_pkg::NO_EFFECT);
        add_cell(OP_DECODE, 3'd2, 8'h20, 8'h22, 8'hFE);
        add_cell(OP_NEW_PATTERN, 3'd5, 8'hFC, 8'h33, tced_pkg::NO_EFFECT);
        add_cell(OP_DECODE, 3'd0, 8'hFB, 8'h44, tced_pkg::NO_EFFECT);
        add_cell(OP_DECODE, 3'd4, 8'h80, 8'h3C, tced_pkg::NO_EFFECT);

        for (int n = 0; n < RANDOM_CELLS; n++)
        begin
            o = ($urandom_range(99) < 5) ? OP_NEW_PATTERN : OP_DECODE;
            r = $urandom_range(99);
            if (r < 12)
                nb = tced_pkg::NOTE_VOL_ONLY;
            else if (r < 24)
                nb = tced_pkg::NOTE_EMPTY;
            else
                nb = 8'($urandom_range(8'hFD, 0));
            r = $urandom_range(99);
            if (r < 30)
                eb = tced_pkg::NO_EFFECT;
            else if (r < 75)
                eb = 8'($urandom_range(8'h7F, 0));
            else
                eb = 8'($urandom_range(8'hFF, 0));
            add_cell(o, 3'($urandom_range(7)), nb, 8'($urandom_range(8'hFF, 0)), eb);
        end
        total_cells = pending_cells.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cells_accepted < total_cells || results_checked < total_cells)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_cells.size() != 0)
            report_mismatch("results missing", expected_cells.size(), 0);

        if (mismatches == 0)
            $display("tb_tracker_cell_effect_decoder passed");
        else
            $display("tb_tracker_cell_effect_decoder failed");
        $finish;
    end

endmodule
